// File: sv/siq_pkg.sv
// Shared types and constants for the sorted insertion queue.
package siq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 32;
    localparam int KEY_W = 10;
    localparam int OCC_W = 6;

    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  ctype;
        logic [7:0]  pay;
        logic [9:0]  items;
        logic        flag;
    } entry_t;

    typedef enum logic [2:0] {
        CMD_PUSH_FRONT = 3'd0,
        CMD_PUSH_BACK  = 3'd1,
        CMD_SORTED     = 3'd2,
        CMD_POP        = 3'd3,
        CMD_REMOVE     = 3'd4
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_APPLY = 1'b1
    } state_t;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic eval;     // latch per-cell hit for the incoming transaction
        cmd_t cmd;
        logic key_sel;
        logic insert;   // open a slot at the first hit, take new entry there
        logic extract;  // close the slot at the first hit
    } cell_ctrl_t;

endpackage

// File: sv/siq_cell.sv
// One queue slot: holds an entry, flags where it stands relative to the command, shifts.
module siq_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  siq_pkg::cell_ctrl_t ctrl,
    input  logic               is_head,
    input  siq_pkg::entry_t    eval_entry,
    input  siq_pkg::entry_t    new_entry,
    input  siq_pkg::entry_t    prev_entry,
    input  logic               prev_valid,
    input  siq_pkg::entry_t    next_entry,
    input  logic               next_valid,
    input  logic               chain_in,
    output logic               chain_out,
    output logic               pos,
    output siq_pkg::entry_t    entry,
    output logic               valid
);
    import siq_pkg::*;

    entry_t           entry_reg;
    logic             valid_reg;
    logic             hit_reg;
    logic             hit_next;
    logic [KEY_W-1:0] own_key;
    logic [KEY_W-1:0] new_key;

    assign own_key = ctrl.key_sel ? entry_reg.items : KEY_W'(entry_reg.ctype);
    assign new_key = ctrl.key_sel ? eval_entry.items : KEY_W'(eval_entry.ctype);

    always_comb
    begin
        case (ctrl.cmd)
            CMD_PUSH_FRONT: hit_next = 1'b1;
            CMD_POP:        hit_next = 1'b1;
            CMD_PUSH_BACK:  hit_next = !valid_reg;
            // on a tie with the head the new entry goes first, later slots keep ties ahead of the new entry
            CMD_SORTED:     hit_next = !valid_reg ||
                                       (is_head ? (own_key >= new_key) : (own_key > new_key));
            CMD_REMOVE:     hit_next = valid_reg && (entry_reg.id == eval_entry.id);
            default:        hit_next = 1'b0;
        endcase
    end

    // chain_in: some earlier slot is at or past the target position
    assign chain_out = chain_in | hit_reg;
    assign pos       = hit_reg & !chain_in;
    assign entry     = entry_reg;
    assign valid     = valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.eval)
            begin
                hit_reg <= hit_next;
            end
            if (ctrl.insert)
            begin
                if (chain_in)
                begin
                    valid_reg <= prev_valid;
                end
                else if (hit_reg)
                begin
                    valid_reg <= 1'b1;
                end
            end
            else if (ctrl.extract && chain_out)
            begin
                valid_reg <= next_valid;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.insert)
        begin
            if (chain_in)
            begin
                entry_reg <= prev_entry;
            end
            else if (hit_reg)
            begin
                entry_reg <= new_entry;
            end
        end
        else if (ctrl.extract && chain_out)
        begin
            entry_reg <= next_entry;
        end
    end

endmodule

// File: sv/sorted_insertion_queue.sv
// Sorted insertion queue: a row of QUEUE_DEPTH slot cells kept in order, head at slot 0.
// Each transaction runs in two states: on acceptance every cell compares its entry with the
// command (key or id) and latches a hit flag; in S_APPLY a prefix OR of those flags runs
// along the row, marks the target slot, and the cells from it to the tail shift by one
// toward or away from it while the result is loaded into the output register. A new
// transaction is accepted only in S_IDLE, after the previous one has committed; a result
// held by out_stall delays the shift of the following transaction until it is drained.
module sorted_insertion_queue #(
    parameter int QUEUE_DEPTH = siq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write_en,
    input  logic        cfg_write_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [15:0] customer_id,
    input  logic [7:0]  client_type,
    input  logic [7:0]  payment_method,
    input  logic [9:0]  item_count,
    input  logic        removed_flag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic [15:0] out_customer_id,
    output logic [7:0]  out_client_type,
    output logic [7:0]  out_payment_method,
    output logic [9:0]  out_item_count,
    output logic        out_removed_flag,
    output logic [5:0]  occupancy
);
    import siq_pkg::*;

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t           state_reg;
    state_t           state_next;
    logic             sort_key_select_reg;
    cmd_t             cmd_reg;
    entry_t           new_entry_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    logic             out_valid_reg;
    status_t          status_reg;
    status_t          status_next;
    entry_t           out_entry_reg;
    logic [CNT_W-1:0] occ_reg;

    logic             accept;
    logic             commit;
    logic             full;
    logic             empty;
    logic             found;
    logic             do_insert;
    logic             do_extract;
    entry_t           in_entry;
    entry_t           taken;
    cell_ctrl_t       ctrl;

    entry_t           cell_entry [QUEUE_DEPTH];
    logic             cell_valid [QUEUE_DEPTH];
    logic             cell_pos   [QUEUE_DEPTH];
    logic             chain      [QUEUE_DEPTH+1];

    assign in_entry.id    = customer_id;
    assign in_entry.ctype = client_type;
    assign in_entry.pay   = payment_method;
    assign in_entry.items = item_count;
    assign in_entry.flag  = removed_flag;

    assign accept = in_valid && !in_stall;
    assign full   = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty  = (count_reg == '0);
    assign found  = chain[QUEUE_DEPTH];

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        commit     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    state_next = S_APPLY;
                end
            end
            S_APPLY:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    commit     = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        status_next = ST_OK;
        do_insert   = 1'b0;
        do_extract  = 1'b0;
        case (cmd_reg)
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED:
            begin
                status_next = full ? ST_FULL : ST_OK;
                do_insert   = !full;
            end
            CMD_POP:
            begin
                status_next = empty ? ST_EMPTY : ST_OK;
                do_extract  = !empty;
            end
            CMD_REMOVE:
            begin
                if (empty)
                begin
                    status_next = ST_EMPTY;
                end
                else if (!found)
                begin
                    status_next = ST_NOT_FOUND;
                end
                else
                begin
                    do_extract = 1'b1;
                end
            end
            default:
            begin
                status_next = ST_OK;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (do_insert)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_extract)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign ctrl.eval    = accept;
    assign ctrl.cmd     = accept ? cmd_t'(command) : cmd_reg;
    assign ctrl.key_sel = sort_key_select_reg;
    assign ctrl.insert  = commit && do_insert;
    assign ctrl.extract = commit && do_extract;

    assign chain[0] = 1'b0;

    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        entry_t prev_e;
        logic   prev_v;
        entry_t next_e;
        logic   next_v;

        if (i == 0)
        begin : g_first
            assign prev_e = new_entry_reg;
            assign prev_v = 1'b0;
        end
        else
        begin : g_mid
            assign prev_e = cell_entry[i-1];
            assign prev_v = cell_valid[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign next_e = new_entry_reg;
            assign next_v = 1'b0;
        end
        else
        begin : g_inner
            assign next_e = cell_entry[i+1];
            assign next_v = cell_valid[i+1];
        end

        siq_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .is_head    ((i == 0) ? 1'b1 : 1'b0),
            .eval_entry (in_entry),
            .new_entry  (new_entry_reg),
            .prev_entry (prev_e),
            .prev_valid (prev_v),
            .next_entry (next_e),
            .next_valid (next_v),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .pos        (cell_pos[i]),
            .entry      (cell_entry[i]),
            .valid      (cell_valid[i])
        );
    end

    // exactly one slot is marked when an extract happens
    always_comb
    begin
        taken = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            taken = taken | (cell_pos[i] ? cell_entry[i] : entry_t'('0));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            sort_key_select_reg <= 1'b0;
            count_reg           <= '0;
            out_valid_reg       <= 1'b0;
            cmd_reg             <= CMD_PUSH_FRONT;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write_en)
            begin
                sort_key_select_reg <= cfg_write_data;
            end
            if (accept)
            begin
                cmd_reg <= cmd_t'(command);
            end
            if (commit)
            begin
                count_reg     <= count_next;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_entry_reg <= in_entry;
        end
        if (commit)
        begin
            status_reg    <= status_next;
            out_entry_reg <= do_extract ? taken : entry_t'('0);
            occ_reg       <= count_next;
        end
    end

    assign out_valid          = out_valid_reg;
    assign status             = status_reg;
    assign out_customer_id    = out_entry_reg.id;
    assign out_client_type    = out_entry_reg.ctype;
    assign out_payment_method = out_entry_reg.pay;
    assign out_item_count     = out_entry_reg.items;
    assign out_removed_flag   = out_entry_reg.flag;
    assign occupancy          = OCC_W'(occ_reg);

endmodule

// File: test/sorted_insertion_queue_tb.sv
// Testbench for the sorted insertion queue: directed table, then random phases checked against a queue model.
module sorted_insertion_queue_tb;
    import siq_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH;
    localparam logic [2:0] CMD_UNUSED_LO  = 3'd5;
    localparam logic [2:0] CMD_UNUSED_MID = 3'd6;
    localparam logic [2:0] CMD_UNUSED_HI  = 3'd7;
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD = 80;
    localparam int SETTLE_CYCLES = 6;

    typedef struct packed {
        status_t     st;
        entry_t      ent;
        logic [5:0]  occ;
    } outcome_t;

    typedef struct packed {
        logic [2:0] cmd;
        entry_t     ent;
        logic       typed;   // want holds a hand-written result
        outcome_t   want;
    } row_t;

    localparam outcome_t FROM_MODEL = '0;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_write_en = 1'b0;
    logic        cfg_write_data = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [2:0]  command = '0;
    logic [15:0] customer_id = '0;
    logic [7:0]  client_type = '0;
    logic [7:0]  payment_method = '0;
    logic [9:0]  item_count = '0;
    logic        removed_flag = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  status;
    logic [15:0] out_customer_id;
    logic [7:0]  out_client_type;
    logic [7:0]  out_payment_method;
    logic [9:0]  out_item_count;
    logic        out_removed_flag;
    logic [5:0]  occupancy;

    entry_t   model_entries[$];
    logic     model_key_sel = 1'b0;
    outcome_t expected_outcomes[$];
    row_t     dir_rows[$];
    int       errors = 0;
    bit       send_idle = 1'b0;
    bit       recv_idle = 1'b0;
    int       long_hold_cycles = 0;

    sorted_insertion_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) uut (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_write_en       (cfg_write_en),
        .cfg_write_data     (cfg_write_data),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .command            (command),
        .customer_id        (customer_id),
        .client_type        (client_type),
        .payment_method     (payment_method),
        .item_count         (item_count),
        .removed_flag       (removed_flag),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .out_customer_id    (out_customer_id),
        .out_client_type    (out_client_type),
        .out_payment_method (out_payment_method),
        .out_item_count     (out_item_count),
        .out_removed_flag   (out_removed_flag),
        .occupancy          (occupancy)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [9:0] sort_key(input entry_t e);
        return model_key_sel ? e.items : {2'b00, e.ctype};
    endfunction

    // Applies one command to the model queue and returns the result it produces.
    function automatic outcome_t predict_queue(input logic [2:0] cmd, input entry_t e);
        outcome_t   res;
        int         pos;
        logic [9:0] k;
        res.st = ST_OK;
        res.ent = '0;
        if (cmd == CMD_PUSH_FRONT || cmd == CMD_PUSH_BACK || cmd == CMD_SORTED)
        begin
            if (model_entries.size() >= QUEUE_DEPTH)
                res.st = ST_FULL;
            else if (cmd == CMD_PUSH_FRONT)
                model_entries.push_front(e);
            else if (cmd == CMD_PUSH_BACK)
                model_entries.push_back(e);
            else
            begin
                k = sort_key(e);
                pos = 0;
                // ties with the head go in front; elsewhere after the run of equal keys
                if (model_entries.size() != 0 && k > sort_key(model_entries[0]))
                begin
                    pos = 1;
                    while (pos < model_entries.size() && sort_key(model_entries[pos]) <= k)
                        pos++;
                end
                model_entries.insert(pos, e);
            end
        end
        else if (cmd == CMD_POP)
        begin
            if (model_entries.size() == 0)
                res.st = ST_EMPTY;
            else
                res.ent = model_entries.pop_front();
        end
        else if (cmd == CMD_REMOVE)
        begin
            if (model_entries.size() == 0)
                res.st = ST_EMPTY;
            else
            begin
                pos = 0;
                while (pos < model_entries.size() && model_entries[pos].id != e.id)
                    pos++;
                if (pos >= model_entries.size())
                    res.st = ST_NOT_FOUND;
                else
                begin
                    res.ent = model_entries[pos];
                    model_entries.delete(pos);
                end
            end
        end
        res.occ = 6'(model_entries.size());
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endfunction

    // Random command; ids come from a small pool often so removes find matches
    // and keys repeat so sorted inserts hit ties.
    function automatic void make_item(input int push_pct, output logic [2:0] cmd,
                                      output entry_t e);
        int pick;
        e.id    = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
        e.ctype = $urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom);
        e.pay   = 8'($urandom);
        e.items = $urandom_range(0, 1) ? 10'($urandom_range(0, 7)) : 10'($urandom);
        e.flag  = 1'($urandom);
        if ($urandom_range(0, 99) < push_pct)
        begin
            pick = $urandom_range(0, 3);
            cmd = (pick == 0) ? CMD_PUSH_FRONT : (pick == 1) ? CMD_PUSH_BACK : CMD_SORTED;
        end
        else
        begin
            pick = $urandom_range(0, 19);
            if (pick < 9)
                cmd = CMD_POP;
            else if (pick < 18)
            begin
                cmd = CMD_REMOVE;
                if (model_entries.size() != 0 && $urandom_range(0, 9) < 7)
                    e.id = model_entries[$urandom_range(0, model_entries.size() - 1)].id;
            end
            else
                cmd = 3'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
        end
    endfunction

    // Entered right after a rising edge; returns right after the accepting edge.
    task automatic offer_item(input logic [2:0] cmd, input entry_t e, input logic typed,
                              input outcome_t want);
        int       gap;
        outcome_t predicted;
        gap = send_idle ? $urandom_range(0, 12) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        customer_id    <= e.id;
        client_type    <= e.ctype;
        payment_method <= e.pay;
        item_count     <= e.items;
        removed_flag   <= e.flag;
        do @(posedge clk); while (in_stall);
        predicted = predict_queue(cmd, e);
        expected_outcomes.push_back(typed ? want : predicted);
    endtask

    task automatic wait_for_results();
        in_valid <= 1'b0;
        while (expected_outcomes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_sort_key(input logic sel);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= sel;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        model_key_sel = sel;
    endtask

    initial
    begin : result_sink
        int unsigned hold;
        outcome_t    want;
        wait (rst_n === 1'b1);
        forever
        begin
            if (long_hold_cycles > 0)
            begin
                hold = long_hold_cycles;
                long_hold_cycles = 0;
            end
            else
                hold = recv_idle ? $urandom_range(0, 12) : 0;
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (out_valid !== 1'b1);
            if (expected_outcomes.size() == 0)
            begin
                $display("%0t: result with no transaction pending, status 0x%0h occupancy %0d",
                         $time, status, occupancy);
                errors++;
            end
            else
            begin
                want = expected_outcomes.pop_front();
                check_field("status", want.st, status);
                check_field("out_customer_id", want.ent.id, out_customer_id);
                check_field("out_client_type", want.ent.ctype, out_client_type);
                check_field("out_payment_method", want.ent.pay, out_payment_method);
                check_field("out_item_count", want.ent.items, out_item_count);
                check_field("out_removed_flag", want.ent.flag, out_removed_flag);
                check_field("occupancy", want.occ, occupancy);
            end
        end
    end

    initial
    begin
        #4_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : stimulus
        logic [2:0] cmd;
        entry_t     e;
        int         push_pct[10] = '{60, 90, 100, 50, 0, 20, 60, 100, 30, 50};

        dir_rows.push_back('{CMD_POP, '0, 1'b1, '{ST_EMPTY, '0, 6'd0}});
        dir_rows.push_back('{CMD_REMOVE, '0, 1'b1, '{ST_EMPTY, '0, 6'd0}});
        dir_rows.push_back('{CMD_UNUSED_LO, '1, 1'b1, '{ST_OK, '0, 6'd0}});
        dir_rows.push_back('{CMD_SORTED, '1, 1'b1, '{ST_OK, '0, 6'd1}});
        dir_rows.push_back('{CMD_PUSH_FRONT, '0, 1'b1, '{ST_OK, '0, 6'd2}});
        dir_rows.push_back('{CMD_PUSH_BACK, '{16'h5555, 8'h55, 8'hAA, 10'h155, 1'b0},
                             1'b1, '{ST_OK, '0, 6'd3}});
        dir_rows.push_back('{CMD_SORTED, '{16'h1111, 8'h80, 8'h5A, 10'h2AA, 1'b1},
                             1'b0, FROM_MODEL});
        // key equal to the head goes in front of it
        dir_rows.push_back('{CMD_SORTED, '{16'h2222, 8'h00, 8'hA5, 10'h155, 1'b0},
                             1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_SORTED, '{16'h3333, 8'hFF, 8'h0F, 10'h0F0, 1'b1},
                             1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_SORTED, '{16'h4444, 8'h80, 8'hF0, 10'h30F, 1'b0},
                             1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_REMOVE, '{16'h1234, 8'h00, 8'h00, 10'h000, 1'b0},
                             1'b1, '{ST_NOT_FOUND, '0, 6'd7}});
        dir_rows.push_back('{CMD_UNUSED_MID, '0, 1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_UNUSED_HI, '1, 1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_REMOVE, '{16'hFFFF, 8'h00, 8'h00, 10'h000, 1'b0},
                             1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_REMOVE, '{16'h4444, 8'h00, 8'h00, 10'h000, 1'b0},
                             1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_POP, '0, 1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_PUSH_FRONT, '{16'hFFFF, 8'h00, 8'h00, 10'h000, 1'b0},
                             1'b0, FROM_MODEL});
        // id 0 sits right behind the head: remove closes a gap mid-queue
        dir_rows.push_back('{CMD_REMOVE, '0, 1'b0, FROM_MODEL});
        dir_rows.push_back('{CMD_POP, '0, 1'b0, FROM_MODEL});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_sort_key(1'b0);

        foreach (dir_rows[i])
            offer_item(dir_rows[i].cmd, dir_rows[i].ent, dir_rows[i].typed, dir_rows[i].want);

        for (int phase = 0; phase < 10; phase++)
        begin
            wait_for_results();
            set_sort_key(phase < 4 ? 1'(phase) : 1'($urandom));
            if (phase == 0)
            begin
                send_idle = 1'b0;
                recv_idle = 1'b0;
            end
            else if (phase == 3)
            begin
                // sink holds off while the source keeps offering back to back
                send_idle = 1'b0;
                recv_idle = 1'b1;
                long_hold_cycles = LONG_HOLD;
            end
            else
            begin
                send_idle = $urandom_range(0, 3) != 0;
                recv_idle = $urandom_range(0, 3) != 0;
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                make_item(push_pct[phase], cmd, e);
                offer_item(cmd, e, 1'b0, FROM_MODEL);
            end
        end

        wait_for_results();
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
sv/siq_pkg.sv
sv/siq_cell.sv
sv/sorted_insertion_queue.sv
test/sorted_insertion_queue_tb.sv
